// ===== rtl/hbr_pkg.sv =====
// Shared constants, types and tables for the hash to bucket reduction block.
package hbr_pkg;

  localparam int unsigned HashW      = 32;
  localparam int unsigned MaxRetries = 64;
  localparam int unsigned StepW      = $clog2(MaxRetries + 1);
  localparam int unsigned CntW       = $clog2(HashW);

  localparam logic [HashW-1:0] FnvOffset = 32'h811c_9dc5;
  localparam logic [HashW-1:0] AllOnes   = 32'hffff_ffff;

  // The prime 16777619 is 2^24 + 2^8 + 2^7 + 2^4 + 2^1 + 2^0.
  localparam int unsigned FnvTerms = 6;
  localparam int unsigned TermW    = $clog2(FnvTerms);
  localparam logic [4:0] FnvShift [FnvTerms] = '{5'd0, 5'd1, 5'd4, 5'd7, 5'd8, 5'd24};

  localparam logic [2:0] MethPass  = 3'd0;
  localparam logic [2:0] MethMask  = 3'd1;
  localparam logic [2:0] MethFold  = 3'd2;
  localparam logic [2:0] MethMod   = 3'd3;
  localparam logic [2:0] MethRetry = 3'd4;

  localparam int unsigned AddrW = 4;
  localparam logic [1:0] RegMethod = 2'd0;
  localparam logic [1:0] RegBitLen = 2'd1;
  localparam logic [1:0] RegTblLen = 2'd2;

  typedef struct packed {
    logic             start;
    logic [HashW-1:0] dividend;
    logic [HashW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [HashW-1:0] rem;
  } div_rsp_t;

  typedef enum logic [5:0] {
    StIdle  = 6'b000001,
    StFold  = 6'b000010,
    StLevel = 6'b000100,
    StCheck = 6'b001000,
    StMul   = 6'b010000,
    StMod   = 6'b100000
  } state_e;

endpackage

// ===== rtl/hash_to_bucket_reduce.sv =====
// Top level: configuration registers, reduction sequencer and result register.
// Pass-through, mask, full-width fold and zero table length: result registered
// in the cycle after start. Xor fold below 32 bits: one hash bit per cycle.
// Modulo: via the bit-serial remainder unit. Retry: the retry level via that
// unit, rehash steps of six shift-add terms each (up to 64), then the unit again.
// busy_o drops in the result cycle, no stalls; a new item is taken while idle.
// Reset is asynchronous: method 0, bit_length 32, table_length 1024, idle.
module hash_to_bucket_reduce import hbr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  logic [HashW-1:0] hash_value_i,
  output logic             done_o,
  output logic [HashW-1:0] bucket_index_o,
  output logic             retry_exhausted_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [2:0]       method_q;
  logic [5:0]       blen_q;
  logic [HashW-1:0] tlen_q;
  logic             cfg_wr;
  logic [1:0]       cfg_idx;

  state_e           state_q, state_d;
  logic [HashW-1:0] h_q, h_d;
  logic [HashW-1:0] acc_q, acc_d;
  logic [HashW-1:0] level_q, level_d;
  logic [CntW-1:0]  pos_q, pos_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [CntW-1:0]  wlim_q, wlim_d;
  logic [TermW-1:0] term_q, term_d;
  logic [StepW-1:0] steps_q, steps_d;
  logic             ex_q, ex_d;
  logic [HashW-1:0] bucket_q, bucket_d;
  logic             done_q, done_d;

  logic [5:0]       eff_w;
  logic [HashW-1:0] wmask;
  logic [HashW-1:0] fold_acc;
  logic [HashW-1:0] mul_sum;
  logic             above;
  div_req_t         div_req;
  div_rsp_t         div_rsp;

  // configuration port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      method_q <= MethPass;
      blen_q   <= 6'd32;
      tlen_q   <= 32'd1024;
    end else if (cfg_wr) begin
      case (cfg_idx)
        RegMethod: method_q <= pwdata[2:0];
        RegBitLen: blen_q   <= pwdata[5:0];
        RegTblLen: tlen_q   <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      RegMethod: prdata = {29'd0, method_q};
      RegBitLen: prdata = {26'd0, blen_q};
      RegTblLen: prdata = tlen_q;
      default:   prdata = '0;
    endcase
  end

  // effective index width, 1..32
  always_comb begin
    if (blen_q == 6'd0) begin
      eff_w = 6'd1;
    end else if (blen_q > 6'd32) begin
      eff_w = 6'd32;
    end else begin
      eff_w = blen_q;
    end
    if (eff_w >= 6'd32) begin
      wmask = AllOnes;
    end else begin
      wmask = (HashW'(1) << eff_w[4:0]) - HashW'(1);
    end
  end

  assign above   = h_q >= level_q;
  assign mul_sum = acc_q + (h_q << FnvShift[term_q]);

  always_comb begin
    fold_acc          = acc_q;
    fold_acc[pos_q]   = acc_q[pos_q] ^ h_q[0];
  end

  always_comb begin
    state_d  = state_q;
    h_d      = h_q;
    acc_d    = acc_q;
    level_d  = level_q;
    pos_d    = pos_q;
    cnt_d    = cnt_q;
    wlim_d   = wlim_q;
    term_d   = term_q;
    steps_d  = steps_q;
    ex_d     = ex_q;
    bucket_d = bucket_q;
    done_d   = 1'b0;
    div_req  = '{start: 1'b0, dividend: h_q, divisor: tlen_q};
    case (state_q)
      StIdle: begin
        if (start_i) begin
          h_d  = hash_value_i;
          ex_d = 1'b0;
          case (method_q)
            MethMask: begin
              bucket_d = hash_value_i & wmask;
              done_d   = 1'b1;
            end
            MethFold: begin
              if (eff_w >= 6'd32) begin
                bucket_d = hash_value_i;
                done_d   = 1'b1;
              end else begin
                acc_d   = '0;
                pos_d   = '0;
                cnt_d   = '0;
                wlim_d  = eff_w[4:0] - 5'd1;
                state_d = StFold;
              end
            end
            MethMod: begin
              if (tlen_q == '0) begin
                bucket_d = hash_value_i;
                done_d   = 1'b1;
              end else begin
                div_req = '{start: 1'b1, dividend: hash_value_i, divisor: tlen_q};
                state_d = StMod;
              end
            end
            MethRetry: begin
              if (tlen_q == '0) begin
                bucket_d = hash_value_i;
                done_d   = 1'b1;
              end else begin
                // remainder of all-ones gives the largest multiple not above it
                div_req = '{start: 1'b1, dividend: AllOnes, divisor: tlen_q};
                steps_d = '0;
                state_d = StLevel;
              end
            end
            default: begin
              bucket_d = hash_value_i;
              done_d   = 1'b1;
            end
          endcase
        end
      end
      StFold: begin
        // fold hash bit i into index bit i mod width
        acc_d = fold_acc;
        h_d   = {1'b0, h_q[HashW-1:1]};
        pos_d = (pos_q == wlim_q) ? '0 : pos_q + 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntW'(HashW - 1)) begin
          bucket_d = fold_acc;
          done_d   = 1'b1;
          state_d  = StIdle;
        end
      end
      StLevel: begin
        if (div_rsp.done) begin
          level_d = ~div_rsp.rem;
          state_d = StCheck;
        end
      end
      StCheck: begin
        if (above && (steps_q < StepW'(MaxRetries))) begin
          acc_d   = FnvOffset;
          term_d  = '0;
          state_d = StMul;
        end else begin
          ex_d    = above;
          div_req = '{start: 1'b1, dividend: h_q, divisor: tlen_q};
          state_d = StMod;
        end
      end
      StMul: begin
        acc_d  = mul_sum;
        term_d = term_q + 1'b1;
        if (term_q == TermW'(FnvTerms - 1)) begin
          h_d     = mul_sum;
          steps_d = steps_q + 1'b1;
          state_d = StCheck;
        end
      end
      StMod: begin
        if (div_rsp.done) begin
          bucket_d = div_rsp.rem;
          done_d   = 1'b1;
          state_d  = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      done_q  <= 1'b0;
      pos_q   <= '0;
      cnt_q   <= '0;
      wlim_q  <= '0;
      term_q  <= '0;
      steps_q <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      pos_q   <= pos_d;
      cnt_q   <= cnt_d;
      wlim_q  <= wlim_d;
      term_q  <= term_d;
      steps_q <= steps_d;
    end
  end

  always_ff @(posedge clk_i) begin
    h_q      <= h_d;
    acc_q    <= acc_d;
    level_q  <= level_d;
    ex_q     <= ex_d;
    bucket_q <= bucket_d;
  end

  hbr_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign busy_o            = (state_q != StIdle);
  assign done_o            = done_q;
  assign bucket_index_o    = bucket_q;
  assign retry_exhausted_o = done_q & ex_q;

endmodule

// ===== rtl/hbr_div.sv =====
// Bit-serial restoring remainder unit, one quotient bit per cycle.
module hbr_div import hbr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [HashW-1:0] dvd_q, dvd_d;
  logic [HashW-1:0] dsr_q, dsr_d;
  logic [HashW-1:0] rem_q, rem_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             run_q, run_d;
  logic             done_q, done_d;
  logic [HashW:0]   shifted;
  logic [HashW:0]   diff;

  always_comb begin
    dvd_d   = dvd_q;
    dsr_d   = dsr_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    run_d   = run_q;
    done_d  = 1'b0;
    shifted = {rem_q, dvd_q[HashW-1]};
    diff    = shifted - {1'b0, dsr_q};
    if (req_i.start) begin
      dvd_d = req_i.dividend;
      dsr_d = req_i.divisor;
      rem_d = '0;
      cnt_d = '0;
      run_d = 1'b1;
    end else if (run_q) begin
      // shift in the next dividend bit, subtract when it fits
      dvd_d = {dvd_q[HashW-2:0], 1'b0};
      rem_d = diff[HashW] ? shifted[HashW-1:0] : diff[HashW-1:0];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(HashW - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dsr_q <= dsr_d;
    rem_q <= rem_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q;

endmodule

// ===== rtl/hbr_checker.sv =====
// Port-level checker for the reduction block and its bind.
module hbr_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input logic done_o,
  input logic retry_exhausted_o
);

  // exhausted flag only travels with a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    retry_exhausted_o |-> done_o)
    else $error("exhausted flag without result");

  // busy only starts from an accepted item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_o) |-> $past(start_i))
    else $error("busy rose without an accepted item");

  // finishing a long item delivers its result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> done_o)
    else $error("busy fell without a result");

  // every result comes from an item finished straight from idle or the end of a long one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($past(start_i && !busy_o) || $fell(busy_o)))
    else $error("result without a matching item");

endmodule

bind hash_to_bucket_reduce hbr_checker u_hbr_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .start_i           (start_i),
  .busy_o            (busy_o),
  .done_o            (done_o),
  .retry_exhausted_o (retry_exhausted_o)
);

// ===== verif/bucket_checker.sv =====
// Checker for hash_to_bucket_reduce: predicts bucket indexes and compares results.
module bucket_checker import hbr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             busy_i,
  input  logic [HashW-1:0] hash_value_i,
  input  logic             done_i,
  input  logic [HashW-1:0] bucket_index_i,
  input  logic             retry_exhausted_i,
  input  logic             psel_i,
  input  logic             penable_i,
  input  logic             pwrite_i,
  input  logic             pready_i,
  input  logic [AddrW-1:0] paddr_i,
  input  logic [31:0]      pwdata_i,
  output int               pending_o,
  output int               mismatches_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [HashW-1:0] FnvPrime = 32'd16777619;

  typedef struct packed {
    logic [HashW-1:0] bucket;
    logic             exhausted;
  } bucket_t;

  logic [2:0]       cfg_method;
  logic [5:0]       cfg_bit_len;
  logic [HashW-1:0] cfg_tbl_len;
  bucket_t          expected_buckets[$];
  bucket_t          want;
  int               mismatches = 0;

  assign mismatches_o = mismatches;

  function automatic bucket_t reduce_to_bucket(logic [HashW-1:0] h);
    bucket_t          res;
    int unsigned      w;
    int unsigned      steps;
    logic [HashW-1:0] slice_mask;
    logic [HashW-1:0] acc;
    logic [HashW-1:0] level;
    res.exhausted = 1'b0;
    // Out-of-range lengths clamp to 1..32.
    w = (cfg_bit_len == 0) ? 1 : (cfg_bit_len > HashW) ? HashW : cfg_bit_len;
    slice_mask = (w >= HashW) ? AllOnes : (32'd1 << w) - 32'd1;
    case (cfg_method)
      MethMask: res.bucket = h & slice_mask;
      MethFold: begin
        if (w >= HashW) begin
          res.bucket = h;
        end else begin
          acc = '0;
          while (h != 0) begin
            acc ^= h & slice_mask;
            h = h >> w;
          end
          res.bucket = acc;
        end
      end
      MethMod: res.bucket = (cfg_tbl_len == 0) ? h : h % cfg_tbl_len;
      MethRetry: begin
        if (cfg_tbl_len == 0) begin
          res.bucket = h;
        end else begin
          level = (AllOnes / cfg_tbl_len) * cfg_tbl_len;
          steps = 0;
          // Rehash while in the biased top range, bounded by the step limit.
          while (h >= level && steps < MaxRetries) begin
            h = h * FnvPrime + FnvOffset;
            steps++;
          end
          res.exhausted = (h >= level);
          res.bucket = h % cfg_tbl_len;
        end
      end
      default: res.bucket = h;
    endcase
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [HashW-1:0] got,
                                 input logic [HashW-1:0] exp_val);
    $display("MISMATCH %s: got 0x%08h, expected 0x%08h at %0t", what, got, exp_val, $realtime);
    mismatches++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_method  = MethPass;
      cfg_bit_len = 6'd32;
      cfg_tbl_len = 32'd1024;
      expected_buckets.delete();
      pending_o <= 0;
    end else begin
      if (done_i) begin
        if (expected_buckets.size() == 0) begin
          report_mismatch("result with no item pending", bucket_index_i, '0);
        end else begin
          want = expected_buckets.pop_front();
          if (bucket_index_i !== want.bucket)
            report_mismatch("bucket_index", bucket_index_i, want.bucket);
          if (retry_exhausted_i !== want.exhausted)
            report_mismatch("retry_exhausted", 32'(retry_exhausted_i), 32'(want.exhausted));
        end
      end
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[AddrW-1:2])
          RegMethod: cfg_method  = pwdata_i[2:0];
          RegBitLen: cfg_bit_len = pwdata_i[5:0];
          RegTblLen: cfg_tbl_len = pwdata_i;
          default: ;
        endcase
      end
      if (start_i && !busy_i) expected_buckets.push_back(reduce_to_bucket(hash_value_i));
      pending_o <= expected_buckets.size();
    end
  end

endmodule

// ===== verif/tb_top.sv =====
// Testbench top for hash_to_bucket_reduce: clock, reset, stimulus and verdict.
module tb_top;
  import hbr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumMethodCodes = 8;
  localparam int NumBlocks      = 24;
  localparam int ItemsPerBlock  = 71;

  logic             clk_i             = 1'b0;
  logic             rst_ni            = 1'b0;
  logic             start_i           = 1'b0;
  logic [HashW-1:0] hash_value_i      = '0;
  logic             psel              = 1'b0;
  logic             penable           = 1'b0;
  logic             pwrite            = 1'b0;
  logic [AddrW-1:0] paddr             = '0;
  logic [31:0]      pwdata            = '0;
  logic             busy_o;
  logic             done_o;
  logic [HashW-1:0] bucket_index_o;
  logic             retry_exhausted_o;
  logic [31:0]      prdata;
  logic             pready;
  int               pending;
  int               mismatches;
  int               items_sent = 0;
  int               reg_writes = 0;

  always begin
    #5ns clk_i = 1'b1;
    #5ns clk_i = 1'b0;
  end

  hash_to_bucket_reduce u_top (
    .clk_i, .rst_ni, .start_i, .busy_o, .hash_value_i, .done_o, .bucket_index_o,
    .retry_exhausted_o, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  bucket_checker u_checker (
    .clk_i, .rst_ni, .start_i,
    .busy_i            (busy_o),
    .hash_value_i,
    .done_i            (done_o),
    .bucket_index_i    (bucket_index_o),
    .retry_exhausted_i (retry_exhausted_o),
    .psel_i            (psel),
    .penable_i         (penable),
    .pwrite_i          (pwrite),
    .pready_i          (pready),
    .paddr_i           (paddr),
    .pwdata_i          (pwdata),
    .pending_o         (pending),
    .mismatches_o      (mismatches)
  );

  // Hold start high until the block takes the item; the caller lowers it.
  task automatic send_hash(input logic [HashW-1:0] h);
    start_i      <= 1'b1;
    hash_value_i <= h;
    do @(posedge clk_i); while (busy_o);
    items_sent++;
  endtask

  task automatic pause_sender(input int cycles);
    start_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Wait until every pending item has produced its result.
  task automatic drain();
    start_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0 || busy_o);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] wdata);
    drain();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    reg_writes++;
  endtask

  initial begin
    int               gap_pct;
    int               guard;
    logic [2:0]       meth;
    logic [5:0]       blen;
    logic [HashW-1:0] tbl_len;
    logic [HashW-1:0] h;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset settings first, then each method at its edges.
    send_hash(32'h0000_0000);
    send_hash(32'hffff_ffff);
    write_reg(RegMethod, 32'(MethMod));
    send_hash(32'hffff_ffff);
    send_hash(32'd12345);
    write_reg(RegMethod, 32'(MethMask));
    send_hash(32'ha5a5_a5a5);
    write_reg(RegBitLen, 32'd1);
    send_hash(32'hffff_ffff);
    write_reg(RegBitLen, 32'd0);
    send_hash(32'hffff_ffff);
    write_reg(RegBitLen, 32'd63);
    send_hash(32'hdead_beef);
    write_reg(RegMethod, 32'(MethFold));
    write_reg(RegBitLen, 32'd32);
    send_hash(32'hdead_beef);
    write_reg(RegBitLen, 32'd1);
    send_hash(32'hffff_ffff);
    send_hash(32'h7fff_ffff);
    write_reg(RegBitLen, 32'd7);
    send_hash(32'hffff_ffff);
    write_reg(RegBitLen, 32'd0);
    send_hash(32'h8000_0001);
    write_reg(RegMethod, 32'(MethMod));
    write_reg(RegTblLen, 32'd0);
    send_hash(32'hcafe_f00d);
    write_reg(RegTblLen, 32'd1);
    send_hash(32'hffff_ffff);
    write_reg(RegTblLen, 32'hffff_ffff);
    send_hash(32'hffff_ffff);
    send_hash(32'hffff_fffe);
    write_reg(RegMethod, 32'(MethRetry));
    send_hash(32'hffff_ffff);
    write_reg(RegTblLen, 32'h8000_0001);
    send_hash(32'hffff_ffff);
    write_reg(RegTblLen, 32'd0);
    send_hash(32'h1234_5678);
    write_reg(RegTblLen, 32'd1);
    send_hash(32'hffff_ffff);
    for (int code = MethRetry + 1; code < NumMethodCodes; code++) begin
      write_reg(RegMethod, 32'(code));
      send_hash($urandom);
    end

    // Random: after each item the sender pauses while a 22% draw hits, then 67%, then never.
    for (int blk = 0; blk < NumBlocks; blk++) begin
      gap_pct = (blk < NumBlocks / 3) ? 22 : (blk < 2 * NumBlocks / 3) ? 67 : 0;
      meth = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(0, NumMethodCodes - 1))
                                         : 3'($urandom_range(MethMask, MethRetry));
      blen = ($urandom_range(0, 4) == 0) ? 6'($urandom_range(0, 63))
                                         : 6'($urandom_range(1, 32));
      case ($urandom_range(0, 7))
        0: tbl_len = '0;
        1: tbl_len = 32'd1;
        2: tbl_len = AllOnes;
        3: tbl_len = $urandom_range(2, 64);
        4: tbl_len = 32'd1 << $urandom_range(1, 31);
        5: tbl_len = 32'h8000_0000 + $urandom_range(1, 255);
        6: tbl_len = $urandom;
        default: tbl_len = $urandom_range(1000, 100000);
      endcase
      write_reg(RegMethod, 32'(meth));
      write_reg(RegBitLen, 32'(blen));
      write_reg(RegTblLen, tbl_len);
      for (int n = 0; n < ItemsPerBlock; n++) begin
        case ($urandom_range(0, 9))
          4, 5: h = AllOnes - $urandom_range(0, 32'h00ff_ffff);
          6: h = $urandom_range(0, 255);
          7: h = 32'd1 << $urandom_range(0, 31);
          8: h = ($urandom_range(0, 1) == 0) ? '0 : AllOnes;
          9: h = ~(32'd1 << $urandom_range(0, 31));
          default: h = $urandom;
        endcase
        send_hash(h);
        if ($urandom_range(0, 59) == 0) begin
          drain();
        end else begin
          while ($urandom_range(1, 100) <= gap_pct) pause_sender(1);
        end
      end
    end

    start_i <= 1'b0;
    guard = 0;
    do begin
      @(posedge clk_i);
      guard++;
    end while ((pending != 0 || busy_o) && guard < 2000);
    repeat (600) @(posedge clk_i);

    $display("Covered %0d hash items over %0d register writes, all eight method codes,",
             items_sent, reg_writes);
    $display("zero and oversized lengths, full-range tables and sender gaps and drains.");
    if (mismatches == 0 && pending == 0) begin
      $display("hash_to_bucket_reduce test passed");
    end else begin
      $display("hash_to_bucket_reduce test failed");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("hash_to_bucket_reduce test failed");
    $finish;
  end

endmodule
